### design/fbrd_pkg.sv
package fbrd_pkg;

	localparam int CW   = 9;
	localparam int XW   = CW + 1;
	localparam int CHW  = 8;
	localparam int PIXW = 4 * CHW;
	localparam int OPW  = 3;

	localparam int CFG_IW = 2;
	localparam int CFG_DW = CW;

	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;

	localparam logic [CW-1:0]   IMG_SIZE_RESET = 9'd256;
	localparam logic [PIXW-1:0] OPAQUE_BLACK   = {8'd255, 8'd0, 8'd0, 8'd0};

	typedef enum logic [CFG_IW-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1
	} reg_idx_t;

	typedef enum logic [OPW-1:0] {
		OP_SET     = 3'd0,
		OP_GET     = 3'd1,
		OP_CLEAR   = 3'd2,
		OP_FILL    = 3'd3,
		OP_OUTLINE = 3'd4
	} op_t;

endpackage

### design/fbrd_cmd_if.sv
interface fbrd_cmd_if;

	logic                       valid;
	logic                       ready;
	logic [fbrd_pkg::OPW-1:0]   operation;
	logic [fbrd_pkg::CW-1:0]    start_x;
	logic [fbrd_pkg::CW-1:0]    start_y;
	logic [fbrd_pkg::CW-1:0]    end_x;
	logic [fbrd_pkg::CW-1:0]    end_y;
	logic [fbrd_pkg::CHW-1:0]   red;
	logic [fbrd_pkg::CHW-1:0]   green;
	logic [fbrd_pkg::CHW-1:0]   blue;
	logic [fbrd_pkg::CHW-1:0]   alpha;

	modport source (
		output valid, operation, start_x, start_y, end_x, end_y, red, green, blue, alpha,
		input  ready
	);

	modport sink (
		input  valid, operation, start_x, start_y, end_x, end_y, red, green, blue, alpha,
		output ready
	);

endinterface

### design/fbrd_rsp_if.sv
interface fbrd_rsp_if;

	logic                       valid;
	logic                       ready;
	logic [fbrd_pkg::CHW-1:0]   read_red;
	logic [fbrd_pkg::CHW-1:0]   read_green;
	logic [fbrd_pkg::CHW-1:0]   read_blue;
	logic [fbrd_pkg::CHW-1:0]   read_alpha;
	logic                       in_bounds;

	modport source (
		output valid, read_red, read_green, read_blue, read_alpha, in_bounds,
		input  ready
	);

	modport sink (
		input  valid, read_red, read_green, read_blue, read_alpha, in_bounds,
		output ready
	);

endinterface

### design/framebuffer_rect_draw_unit.sv
// RGBA framebuffer of up to MAX_WIDTH x MAX_HEIGHT 32-bit pixels, stored row-major at
// y*width+x, with set pixel, get pixel, clear, fill rectangle and outline rectangle
// requests. One request is handled at a time: cmd.ready is high only while the unit
// is idle, and one response is returned per request, held until taken (the next
// request may run while it waits). A single pixel walker steps over the pixels of
// each span, one pixel per cycle into one address multiplier and one RAM port.
// Each request passes through the load, scan, drain and done states, the scan being
// skipped for an empty span; an outline loads its top, bottom, left and right edges
// in turn and walks only the pixels of nonempty edges. The pixel store is not
// initialized: a pixel must be written before it is read.
module framebuffer_rect_draw_unit #(
	parameter int MAX_WIDTH  = fbrd_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = fbrd_pkg::MAX_HEIGHT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [fbrd_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [fbrd_pkg::CFG_DW-1:0]   cfg_data,
	fbrd_cmd_if.sink                      cmd,
	fbrd_rsp_if.source                    rsp
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = fbrd_pkg::CW;
	localparam int XW    = fbrd_pkg::XW;
	localparam int PW    = 2 * CW;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		PASS_TOP,
		PASS_BOTTOM,
		PASS_LEFT,
		PASS_RIGHT
	} pass_t;

	// configuration
	logic [CW-1:0] image_width_q;
	logic [CW-1:0] image_height_q;
	logic [CW-1:0] w_eff;
	logic [CW-1:0] h_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= fbrd_pkg::IMG_SIZE_RESET;
			image_height_q <= fbrd_pkg::IMG_SIZE_RESET;
		end else if (cfg_we) begin
			if (cfg_index == fbrd_pkg::REG_WIDTH) begin
				image_width_q <= cfg_data;
			end
			if (cfg_index == fbrd_pkg::REG_HEIGHT) begin
				image_height_q <= cfg_data;
			end
		end
	end

	assign w_eff = (32'(image_width_q) > MAX_WIDTH) ? CW'(MAX_WIDTH) : image_width_q;
	assign h_eff = (32'(image_height_q) > MAX_HEIGHT) ? CW'(MAX_HEIGHT) : image_height_q;

	// request fields
	state_t                        state_q;
	pass_t                         pass_q;
	pass_t                         pass_nxt;
	logic [fbrd_pkg::OPW-1:0]      op_q;
	logic [CW-1:0]                 sx_q;
	logic [CW-1:0]                 sy_q;
	logic [CW-1:0]                 ex_q;
	logic [CW-1:0]                 ey_q;
	logic [fbrd_pkg::PIXW-1:0]     colour_q;
	logic [XW-1:0]                 x_q;
	logic [XW-1:0]                 y_q;
	logic                          hit_q;

	logic                          rsp_valid_q;
	logic [fbrd_pkg::PIXW-1:0]     rsp_colour_q;
	logic                          rsp_in_bounds_q;

	logic [CW-1:0]                 ex_clamp;
	logic [CW-1:0]                 ey_clamp;
	logic [XW-1:0]                 xa;
	logic [XW-1:0]                 xb;
	logic [XW-1:0]                 ya;
	logic [XW-1:0]                 yb;
	logic                          span_empty;
	logic                          last_pass;
	logic                          in_img;
	logic                          x_wrap;
	logic                          y_wrap;
	logic                          single_px;
	logic                          rsp_load;
	logic [fbrd_pkg::PIXW-1:0]     ram_rdata;

	assign ex_clamp = (cmd.end_x > w_eff) ? w_eff : cmd.end_x;
	assign ey_clamp = (cmd.end_y > h_eff) ? h_eff : cmd.end_y;

	// span of the current pass
	always_comb begin
		xa = '0;
		xb = '0;
		ya = '0;
		yb = '0;
		unique case (op_q)
			fbrd_pkg::OP_SET, fbrd_pkg::OP_GET: begin
				xa = XW'(sx_q);
				xb = XW'(sx_q) + XW'(1);
				ya = XW'(sy_q);
				yb = XW'(sy_q) + XW'(1);
			end
			fbrd_pkg::OP_CLEAR: begin
				xb = XW'(w_eff);
				yb = XW'(h_eff);
			end
			fbrd_pkg::OP_FILL: begin
				xa = XW'(sx_q);
				xb = XW'(ex_q);
				ya = XW'(sy_q);
				yb = XW'(ey_q);
			end
			fbrd_pkg::OP_OUTLINE: begin
				unique case (pass_q)
					PASS_TOP: begin
						xa = XW'(sx_q);
						xb = XW'(ex_q);
						ya = XW'(sy_q);
						yb = XW'(sy_q) + XW'(1);
					end
					PASS_BOTTOM: begin
						xa = XW'(sx_q);
						xb = XW'(ex_q);
						// bottom edge above row zero is off the image
						if (ey_q != '0) begin
							ya = XW'(ey_q) - XW'(1);
							yb = XW'(ey_q);
						end
					end
					PASS_LEFT: begin
						xa = XW'(sx_q);
						xb = XW'(sx_q) + XW'(1);
						ya = XW'(sy_q);
						yb = XW'(ey_q);
					end
					PASS_RIGHT: begin
						if (ex_q != '0) begin
							xa = XW'(ex_q) - XW'(1);
							xb = XW'(ex_q);
						end
						ya = XW'(sy_q);
						yb = XW'(ey_q);
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		unique case (pass_q)
			PASS_TOP:    pass_nxt = PASS_BOTTOM;
			PASS_BOTTOM: pass_nxt = PASS_LEFT;
			PASS_LEFT:   pass_nxt = PASS_RIGHT;
			PASS_RIGHT:  pass_nxt = PASS_RIGHT;
			default:     pass_nxt = PASS_RIGHT;
		endcase
	end

	assign span_empty = (xa >= xb) || (ya >= yb);
	assign last_pass  = (op_q != fbrd_pkg::OP_OUTLINE) || (pass_q == PASS_RIGHT);
	assign in_img     = (x_q < XW'(w_eff)) && (y_q < XW'(h_eff));
	assign x_wrap     = (x_q + XW'(1)) >= xb;
	assign y_wrap     = (y_q + XW'(1)) >= yb;
	assign single_px  = (op_q == fbrd_pkg::OP_SET) || (op_q == fbrd_pkg::OP_GET);
	assign rsp_load   = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);

	assign cmd.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			pass_q          <= PASS_TOP;
			op_q            <= '0;
			x_q             <= '0;
			y_q             <= '0;
			hit_q           <= 1'b0;
			rsp_valid_q     <= 1'b0;
			rsp_colour_q    <= '0;
			rsp_in_bounds_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.valid) begin
						op_q    <= cmd.operation;
						pass_q  <= PASS_TOP;
						hit_q   <= 1'b0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (!span_empty) begin
						x_q     <= xa;
						y_q     <= ya;
						state_q <= ST_SCAN;
					end else if (last_pass) begin
						state_q <= ST_DRAIN;
					end else begin
						pass_q <= pass_nxt;
					end
				end
				ST_SCAN: begin
					if (single_px) begin
						hit_q <= in_img;
					end
					if (x_wrap) begin
						x_q <= xa;
						if (y_wrap) begin
							if (last_pass) begin
								state_q <= ST_DRAIN;
							end else begin
								pass_q  <= pass_nxt;
								state_q <= ST_LOAD;
							end
						end else begin
							y_q <= y_q + XW'(1);
						end
					end else begin
						x_q <= x_q + XW'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp_load) begin
						rsp_in_bounds_q <= single_px && hit_q;
						rsp_colour_q    <= (op_q == fbrd_pkg::OP_GET && hit_q) ? ram_rdata : '0;
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request payload, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			sx_q     <= cmd.start_x;
			sy_q     <= cmd.start_y;
			ex_q     <= ex_clamp;
			ey_q     <= ey_clamp;
			colour_q <= {cmd.alpha, cmd.blue, cmd.green, cmd.red};
		end
	end

	// address stage
	logic                      we_s1;
	logic                      re_s1;
	logic [AW-1:0]             addr_s1;
	logic [fbrd_pkg::PIXW-1:0] wdata_s1;
	logic [PW-1:0]             lin_addr;

	assign lin_addr = (PW'(y_q[CW-1:0]) * PW'(w_eff)) + PW'(x_q[CW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			we_s1 <= 1'b0;
			re_s1 <= 1'b0;
		end else begin
			we_s1 <= (state_q == ST_SCAN) && in_img && (op_q != fbrd_pkg::OP_GET);
			re_s1 <= (state_q == ST_SCAN) && in_img && (op_q == fbrd_pkg::OP_GET);
		end
	end

	always_ff @(posedge clk) begin
		addr_s1  <= AW'(lin_addr);
		wdata_s1 <= (op_q == fbrd_pkg::OP_CLEAR) ? fbrd_pkg::OPAQUE_BLACK : colour_q;
	end

	fbrd_ram #(
		.WIDTH (fbrd_pkg::PIXW),
		.DEPTH (DEPTH)
	) u_pixel_ram (
		.clk   (clk),
		.we    (we_s1),
		.re    (re_s1),
		.addr  (addr_s1),
		.wdata (wdata_s1),
		.rdata (ram_rdata)
	);

	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_red   = rsp_colour_q[7:0];
	assign rsp.read_green = rsp_colour_q[15:8];
	assign rsp.read_blue  = rsp_colour_q[23:16];
	assign rsp.read_alpha = rsp_colour_q[31:24];
	assign rsp.in_bounds  = rsp_in_bounds_q;

endmodule

### design/fbrd_ram.sv
module fbrd_ram #(
	parameter int WIDTH = fbrd_pkg::PIXW,
	parameter int DEPTH = fbrd_pkg::MAX_WIDTH_DEF * fbrd_pkg::MAX_HEIGHT_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic             re,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

### design/fbrd_checker.sv
module fbrd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cmd_valid,
	input logic                        cmd_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [fbrd_pkg::CHW-1:0]    rsp_red,
	input logic [fbrd_pkg::CHW-1:0]    rsp_green,
	input logic [fbrd_pkg::CHW-1:0]    rsp_blue,
	input logic [fbrd_pkg::CHW-1:0]    rsp_alpha,
	input logic                        rsp_in_bounds
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("request taken while previous one still running");

	a_out_of_bounds_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_in_bounds |->
			(rsp_red == '0) && (rsp_green == '0) && (rsp_blue == '0) && (rsp_alpha == '0))
		else $error("nonzero colour without in-bounds read");

	a_rsp_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(cmd_ready))
		else $error("response appeared without a running request");

endmodule

bind framebuffer_rect_draw_unit fbrd_checker u_fbrd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd.valid),
	.cmd_ready     (cmd.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_red       (rsp.read_red),
	.rsp_green     (rsp.read_green),
	.rsp_blue      (rsp.read_blue),
	.rsp_alpha     (rsp.read_alpha),
	.rsp_in_bounds (rsp.in_bounds)
);

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
	import fbrd_pkg::*;

	localparam int LIMIT_CYCLES   = 4000000;
	localparam int SETTLE_CYCLES  = 16;
	localparam int PHASES         = 10;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int FB_WORDS       = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;

	localparam logic [OPW-1:0]    OP_SPARE_LO = 3'd5;
	localparam logic [OPW-1:0]    OP_SPARE_HI = 3'd7;
	localparam logic [CFG_IW-1:0] REG_SPARE   = 2'd3;

	typedef struct packed {
		logic [OPW-1:0] op;
		logic [CW-1:0]  sx;
		logic [CW-1:0]  sy;
		logic [CW-1:0]  ex;
		logic [CW-1:0]  ey;
		logic [CHW-1:0] r;
		logic [CHW-1:0] g;
		logic [CHW-1:0] b;
		logic [CHW-1:0] a;
	} draw_req_t;

	typedef struct packed {
		logic [CHW-1:0] r;
		logic [CHW-1:0] g;
		logic [CHW-1:0] b;
		logic [CHW-1:0] a;
		logic           in_bounds;
	} pixel_rsp_t;

	typedef enum logic [1:0] {
		PEND_REQ,
		PEND_CFG,
		PEND_DRAIN
	} pend_kind_t;

	typedef struct {
		pend_kind_t        kind;
		draw_req_t         req;
		logic [CFG_IW-1:0] idx;
		logic [CFG_DW-1:0] data;
	} pend_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_data;

	fbrd_cmd_if cmd_bus ();
	fbrd_rsp_if rsp_bus ();

	framebuffer_rect_draw_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_bus),
		.rsp       (rsp_bus)
	);

	always #5 clk = ~clk;

	pend_t      pending_q[$];
	pixel_rsp_t pixel_rsp_q[$];

	logic [PIXW-1:0] frame_mem [0:FB_WORDS-1];
	int fb_width_reg = int'(IMG_SIZE_RESET);
	int fb_height_reg = int'(IMG_SIZE_RESET);

	int gen_w = int'(IMG_SIZE_RESET);
	int gen_h = int'(IMG_SIZE_RESET);

	int mismatches = 0;
	int rsp_seen = 0;
	int cycle_count = 0;

	draw_req_t on_bus;
	int  req_wait = 0;
	int  req_calm = 0;
	bit  draining = 1'b0;
	int  settle_left = 0;
	int  rsp_stall = 0;
	int  rsp_calm = 0;

	function automatic bit on_image(int x, int y, int w, int h);
		return x >= 0 && y >= 0 && x < w && y < h;
	endfunction

	function automatic void paint(int x, int y, int w, int h, logic [PIXW-1:0] colour);
		if (on_image(x, y, w, h)) begin
			frame_mem[y * w + x] = colour;
		end
	endfunction

	// framebuffer update and readback for one request
	function automatic pixel_rsp_t draw_and_read(draw_req_t q);
		pixel_rsp_t res;
		logic [PIXW-1:0] colour;
		logic [PIXW-1:0] pix;
		int w, h, sx, sy, cx, cy, x, y;
		res = '0;
		w = (fb_width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : fb_width_reg;
		h = (fb_height_reg > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : fb_height_reg;
		sx = int'(q.sx);
		sy = int'(q.sy);
		cx = (int'(q.ex) > w) ? w : int'(q.ex);
		cy = (int'(q.ey) > h) ? h : int'(q.ey);
		colour = {q.a, q.b, q.g, q.r};
		case (q.op)
		OP_SET: begin
			res.in_bounds = on_image(sx, sy, w, h);
			paint(sx, sy, w, h, colour);
		end
		OP_GET: begin
			if (on_image(sx, sy, w, h)) begin
				pix = frame_mem[sy * w + sx];
				res.in_bounds = 1'b1;
				res.r = pix[7:0];
				res.g = pix[15:8];
				res.b = pix[23:16];
				res.a = pix[31:24];
			end
		end
		OP_CLEAR: begin
			for (y = 0; y < h; y++)
				for (x = 0; x < w; x++)
					paint(x, y, w, h, OPAQUE_BLACK);
		end
		OP_FILL: begin
			for (y = sy; y < cy; y++)
				for (x = sx; x < cx; x++)
					paint(x, y, w, h, colour);
		end
		OP_OUTLINE: begin
			for (x = sx; x < cx; x++) begin
				paint(x, sy, w, h, colour);
				paint(x, cy - 1, w, h, colour);
			end
			for (y = sy; y < cy; y++) begin
				paint(sx, y, w, h, colour);
				paint(cx - 1, y, w, h, colour);
			end
		end
		default: begin
		end
		endcase
		return res;
	endfunction

	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0) begin
			calm = $urandom_range(10, 40);
		end
		return $urandom_range(0, 6);
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH @%0t response %0d: %s", $time, rsp_seen, msg);
		mismatches++;
	endtask

	task automatic check_field(string name, logic [CHW-1:0] got, logic [CHW-1:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %h expected %h", name, got, want));
		end
	endtask

	task automatic queue_req(logic [OPW-1:0] op, int sx, int sy, int ex, int ey,
			logic [PIXW-1:0] colour);
		pend_t p;
		p.kind = PEND_REQ;
		p.req.op = op;
		p.req.sx = CW'(sx);
		p.req.sy = CW'(sy);
		p.req.ex = CW'(ex);
		p.req.ey = CW'(ey);
		p.req.r = colour[7:0];
		p.req.g = colour[15:8];
		p.req.b = colour[23:16];
		p.req.a = colour[31:24];
		p.idx = '0;
		p.data = '0;
		pending_q.push_back(p);
	endtask

	task automatic queue_cfg(logic [CFG_IW-1:0] idx, int data);
		pend_t p;
		p.kind = PEND_CFG;
		p.req = '0;
		p.idx = idx;
		p.data = CFG_DW'(data);
		pending_q.push_back(p);
	endtask

	// wait for the pipe to empty, resize the image, then clear it
	task automatic queue_phase(int w, int h);
		pend_t p;
		p.kind = PEND_DRAIN;
		p.req = '0;
		p.idx = '0;
		p.data = '0;
		pending_q.push_back(p);
		queue_cfg(REG_WIDTH, w);
		queue_cfg(REG_HEIGHT, h);
		queue_cfg(REG_SPARE, $urandom_range(0, 511));
		gen_w = w;
		gen_h = h;
		queue_req(OP_CLEAR, $urandom_range(0, 511), $urandom_range(0, 511),
			$urandom_range(0, 511), $urandom_range(0, 511), $urandom);
	endtask

	function automatic int pick_coord(int span);
		if ($urandom_range(0, 6) == 0) begin
			return $urandom_range(0, 511);
		end
		return $urandom_range(0, span - 1);
	endfunction

	function automatic int pick_end(int start, bit wide);
		if (wide) begin
			return $urandom_range(0, 511);
		end
		if ($urandom_range(0, 7) == 0) begin
			return $urandom_range(0, start);
		end
		return (start + $urandom_range(0, 12) > 511) ? 511 : start + $urandom_range(0, 12);
	endfunction

	task automatic queue_random_req();
		int roll, sx, sy, ex, ey;
		bit tiny;
		roll = $urandom_range(0, 99);
		sx = pick_coord(gen_w);
		sy = pick_coord(gen_h);
		tiny = gen_w * gen_h <= 4096;
		if (roll < 28) begin
			queue_req(OP_SET, sx, sy, $urandom_range(0, 511), $urandom_range(0, 511), $urandom);
		end else if (roll < 58 || (roll >= 92 && roll < 95 && !tiny)) begin
			queue_req(OP_GET, sx, sy, $urandom_range(0, 511), $urandom_range(0, 511), $urandom);
		end else if (roll < 74) begin
			ex = pick_end(sx, tiny && $urandom_range(0, 4) == 0);
			ey = pick_end(sy, tiny && $urandom_range(0, 4) == 0);
			queue_req(OP_FILL, sx, sy, ex, ey, $urandom);
		end else if (roll < 92) begin
			ex = pick_end(sx, $urandom_range(0, 2) == 0);
			ey = pick_end(sy, $urandom_range(0, 2) == 0);
			queue_req(OP_OUTLINE, sx, sy, ex, ey, $urandom);
		end else if (roll < 95) begin
			queue_req(OP_CLEAR, sx, sy, $urandom_range(0, 511), $urandom_range(0, 511), $urandom);
		end else begin
			queue_req(OPW'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), sx, sy,
				$urandom_range(0, 511), $urandom_range(0, 511), $urandom);
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		logic next_valid;
		logic next_we;
		pend_t item;
		if (!arst_n) begin
			cmd_bus.valid <= 1'b0;
			cfg_we <= 1'b0;
			req_wait = 0;
			draining = 1'b0;
		end else begin
			next_valid = cmd_bus.valid;
			next_we = 1'b0;
			if (cmd_bus.valid && cmd_bus.ready) begin
				pixel_rsp_q.push_back(draw_and_read(on_bus));
				next_valid = 1'b0;
				req_wait = draw_wait(req_calm);
			end
			if (!next_valid) begin
				if (req_wait > 0) begin
					req_wait--;
				end else if (draining) begin
					if (pixel_rsp_q.size() == 0) begin
						if (settle_left > 0) begin
							settle_left--;
						end else begin
							draining = 1'b0;
						end
					end
				end else if (pending_q.size() != 0) begin
					item = pending_q.pop_front();
					case (item.kind)
					PEND_REQ: begin
						on_bus = item.req;
						cmd_bus.operation <= item.req.op;
						cmd_bus.start_x <= item.req.sx;
						cmd_bus.start_y <= item.req.sy;
						cmd_bus.end_x <= item.req.ex;
						cmd_bus.end_y <= item.req.ey;
						cmd_bus.red <= item.req.r;
						cmd_bus.green <= item.req.g;
						cmd_bus.blue <= item.req.b;
						cmd_bus.alpha <= item.req.a;
						next_valid = 1'b1;
					end
					PEND_CFG: begin
						next_we = 1'b1;
						cfg_index <= item.idx;
						cfg_data <= item.data;
						if (item.idx == REG_WIDTH) begin
							fb_width_reg = int'(item.data);
						end else if (item.idx == REG_HEIGHT) begin
							fb_height_reg = int'(item.data);
						end
					end
					default: begin
						draining = 1'b1;
						settle_left = SETTLE_CYCLES;
					end
					endcase
				end
			end
			cmd_bus.valid <= next_valid;
			cfg_we <= next_we;
		end
	end

	// response monitor
	always @(posedge clk or negedge arst_n) begin
		pixel_rsp_t want;
		if (!arst_n) begin
			rsp_bus.ready <= 1'b0;
			rsp_stall = 0;
		end else begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				rsp_seen++;
				if (pixel_rsp_q.size() == 0) begin
					report_mismatch("response with no request outstanding");
				end else begin
					want = pixel_rsp_q.pop_front();
					check_field("read_red", rsp_bus.read_red, want.r);
					check_field("read_green", rsp_bus.read_green, want.g);
					check_field("read_blue", rsp_bus.read_blue, want.b);
					check_field("read_alpha", rsp_bus.read_alpha, want.a);
					check_field("in_bounds", CHW'(rsp_bus.in_bounds), CHW'(want.in_bounds));
				end
				rsp_stall = draw_wait(rsp_calm);
			end
			if (rsp_stall > 0) begin
				rsp_stall--;
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int pw, ph;
		cmd_bus.valid = 1'b0;
		cmd_bus.operation = '0;
		cmd_bus.start_x = '0;
		cmd_bus.start_y = '0;
		cmd_bus.end_x = '0;
		cmd_bus.end_y = '0;
		cmd_bus.red = '0;
		cmd_bus.green = '0;
		cmd_bus.blue = '0;
		cmd_bus.alpha = '0;
		rsp_bus.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;

		// pixels before any clear, only reading what was set; then clear, fill and outline cases
		queue_req(OP_SET, 0, 0, 0, 0, {PIXW{1'b1}});
		queue_req(OP_GET, 0, 0, 511, 511, '0);
		queue_req(OP_SET, 255, 255, 0, 0, $urandom);
		queue_req(OP_GET, 255, 255, 0, 0, $urandom);
		queue_req(OP_SET, 256, 0, 0, 0, {PIXW{1'b1}});
		queue_req(OP_GET, 0, 256, 0, 0, $urandom);
		queue_req(OP_GET, 511, 511, 511, 511, {PIXW{1'b1}});
		queue_req(OP_SPARE_LO, 3, 3, 9, 9, $urandom);
		queue_req(OP_SPARE_HI, 511, 511, 511, 511, {PIXW{1'b1}});
		queue_req(OP_GET, 255, 255, 0, 0, '0);
		queue_req(OP_CLEAR, 0, 0, 0, 0, $urandom);
		queue_req(OP_GET, 17, 200, 0, 0, '0);
		queue_req(OP_FILL, 0, 0, 511, 511, $urandom);
		queue_req(OP_GET, 128, 77, 0, 0, '0);
		queue_req(OP_FILL, 10, 10, 10, 20, $urandom);
		queue_req(OP_FILL, 20, 5, 10, 9, $urandom);
		queue_req(OP_OUTLINE, 5, 5, 0, 0, $urandom);
		queue_req(OP_OUTLINE, 0, 0, 0, 7, $urandom);
		queue_req(OP_OUTLINE, 250, 250, 511, 511, $urandom);
		queue_req(OP_OUTLINE, 3, 3, 4, 9, $urandom);
		queue_req(OP_GET, 255, 252, 0, 0, '0);
		queue_req(OP_GET, 3, 8, 0, 0, '0);
		queue_req(OP_GET, 252, 250, 0, 0, '0);
		queue_req(OP_FILL, 40, 40, 43, 42, $urandom);
		queue_req(OP_GET, 42, 41, 0, 0, '0);

		for (int i = 0; i < PHASES; i++) begin
			case (i)
			0: begin pw = 1; ph = 1; end
			1: begin pw = 256; ph = 1; end
			2: begin pw = 1; ph = 256; end
			3: begin pw = 255; ph = 3; end
			4: begin pw = 3; ph = 255; end
			9: begin pw = 256; ph = 256; end
			default: begin
				pw = $urandom_range(1, 48);
				ph = $urandom_range(1, 48);
			end
			endcase
			queue_phase(pw, ph);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				queue_random_req();
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		do @(negedge clk);
		while (pending_q.size() != 0 || cmd_bus.valid || draining || pixel_rsp_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pixel_rsp_q.size() != 0) begin
			report_mismatch($sformatf("%0d responses never arrived", pixel_rsp_q.size()));
		end

		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

### sim.f
design/fbrd_pkg.sv
design/fbrd_cmd_if.sv
design/fbrd_rsp_if.sv
design/fbrd_ram.sv
design/framebuffer_rect_draw_unit.sv
design/fbrd_checker.sv
sim/tb.sv
